>>> rtl/plin_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared widths, breakpoint record, operation codes and divider status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plin_pkg;

  localparam int MaxPoints = 64;
  localparam int DataW     = 32;
  localparam int CountW    = 7;
  localparam int IndexW    = 6;
  localparam int ProdW     = 2 * DataW;
  localparam int QuoClampW = 34;

  localparam logic [CountW-1:0] PointsReset = 7'd2;

  typedef enum logic {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef struct packed {
    logic [DataW-1:0] y;
    logic [DataW-1:0] x;
  } point_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

>>> rtl/plin_mem.sv
// ----------------------------------------------------------------------------
// Breakpoint table
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plin_mem #(
  parameter int Depth = plin_pkg::MaxPoints
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] waddr_i,
  input  plin_pkg::point_t         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(Depth)-1:0] raddr_i,
  output plin_pkg::point_t         rdata_o
);

  plin_pkg::point_t mem_q [Depth];
  plin_pkg::point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/plin_div.sv
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plin_div (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  [plin_pkg::ProdW-1:0]     dividend_i,
  input  wire  [plin_pkg::DataW-1:0]     divisor_i,
  output plin_pkg::div_status_t          status_o,
  output logic [plin_pkg::ProdW-1:0]     quotient_o
);

  localparam int CntW = $clog2(plin_pkg::ProdW + 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [plin_pkg::DataW:0]   rem_q, rem_d;
  logic [plin_pkg::ProdW-1:0] quo_q, quo_d;
  logic [plin_pkg::DataW-1:0] div_q, div_d;
  logic [plin_pkg::DataW:0]   rem_sh;
  logic                       take;

  assign rem_sh = {rem_q[plin_pkg::DataW-1:0], quo_q[plin_pkg::ProdW-1]};
  assign take   = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(plin_pkg::ProdW);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = take ? (rem_sh - {1'b0, div_q}) : rem_sh;
      quo_d = {quo_q[plin_pkg::ProdW-2:0], take};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

`default_nettype wire

>>> rtl/plin_ctrl.sv
// ----------------------------------------------------------------------------
// Interpolator sequencer
// Writes loads into the table, runs end checks, segment search and the
// interpolation arithmetic for queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plin_ctrl #(
  parameter int MAX_POINTS = plin_pkg::MaxPoints
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  [0:0]                         operation_i,
  input  wire  [plin_pkg::IndexW-1:0]        point_index_i,
  input  wire  [plin_pkg::DataW-1:0]         point_x_i,
  input  wire  [plin_pkg::DataW-1:0]         point_y_i,
  input  wire  [plin_pkg::DataW-1:0]         query_x_i,
  input  wire  [plin_pkg::CountW-1:0]        points_in_use_i,
  output logic                               mem_we_o,
  output logic [$clog2(MAX_POINTS)-1:0]      mem_waddr_o,
  output plin_pkg::point_t                   mem_wdata_o,
  output logic                               mem_re_o,
  output logic [$clog2(MAX_POINTS)-1:0]      mem_raddr_o,
  input  plin_pkg::point_t                   mem_rdata_i,
  output logic                               div_start_o,
  output logic [plin_pkg::ProdW-1:0]         div_dividend_o,
  output logic [plin_pkg::DataW-1:0]         div_divisor_o,
  input  plin_pkg::div_status_t              div_status_i,
  input  wire  [plin_pkg::ProdW-1:0]         div_quotient_i,
  output logic                               res_valid_o,
  input  wire                                res_ready_i,
  output logic [plin_pkg::DataW-1:0]         res_y_o,
  output logic                               res_degen_o
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int NW0  = $clog2(MAX_POINTS + 1);
  localparam int NW   = (NW0 > plin_pkg::CountW) ? NW0 : plin_pkg::CountW;
  localparam int DW   = plin_pkg::DataW;
  localparam int QW   = plin_pkg::QuoClampW;
  localparam int SumW = QW + 2;

  localparam logic [plin_pkg::ProdW-1:0] QuoLimit = 64'h0000_0002_0000_0000;
  localparam logic [DW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] SatMin = 32'h8000_0000;

  typedef enum logic [3:0] {
    StIdle,
    StRdLast,
    StChkEnds,
    StSearch,
    StDiff,
    StMul,
    StDivGo,
    StDivWait,
    StFix,
    StSum,
    StDone
  } state_e;

  function automatic logic [DW-1:0] mag(input logic [DW:0] v);
    logic [DW:0] neg;
    neg = -v;
    return v[DW] ? neg[DW-1:0] : v[DW-1:0];
  endfunction

  state_e              state_q;
  logic [DW-1:0]       q_q;
  plin_pkg::point_t    lo_q, up_q;
  logic [AW-1:0]       idx_q;
  logic [DW-1:0]       mdx_q, mdy_q, mw_q;
  logic                neg_q, wz_q;
  logic [plin_pkg::ProdW-1:0] prod_q;
  logic [QW:0]         sq_q;
  logic [DW-1:0]       res_y_q;
  logic                res_degen_q;

  logic                accept;
  logic [NW-1:0]       n_raw, n_use, idx_ext;
  logic [AW-1:0]       last_idx;
  logic                q_lt_lo, q_gt_rd, search_go;
  logic [DW:0]         dx, dy, w;
  logic [QW-1:0]       quo_c;
  logic [QW:0]         sq;
  logic [SumW-1:0]     sum;
  logic [DW-1:0]       sat;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  assign n_raw    = NW'(points_in_use_i);
  assign n_use    = (n_raw < NW'(2)) ? NW'(2) :
                    (n_raw > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : n_raw;
  assign last_idx = AW'(n_use - NW'(1));
  assign idx_ext  = NW'(point_index_i);

  assign q_lt_lo   = $signed(q_q) < $signed(lo_q.x);
  assign q_gt_rd   = $signed(q_q) > $signed(mem_rdata_i.x);
  assign search_go = (idx_q != '0) && ($signed(q_q) < $signed(mem_rdata_i.x));

  assign dx = {q_q[DW-1], q_q} - {lo_q.x[DW-1], lo_q.x};
  assign dy = {up_q.y[DW-1], up_q.y} - {lo_q.y[DW-1], lo_q.y};
  assign w  = {up_q.x[DW-1], up_q.x} - {lo_q.x[DW-1], lo_q.x};

  assign quo_c = (div_quotient_i > QuoLimit) ? QuoLimit[QW-1:0] : div_quotient_i[QW-1:0];
  assign sq    = (neg_q && (prod_q != '0)) ? -{1'b0, quo_c} : {1'b0, quo_c};

  assign sum = {{(SumW-DW){lo_q.y[DW-1]}}, lo_q.y} + {{(SumW-QW-1){sq_q[QW]}}, sq_q};
  always_comb begin
    if (sum[SumW-1:DW-1] == '0 || sum[SumW-1:DW-1] == '1) begin
      sat = sum[DW-1:0];
    end else if (sum[SumW-1]) begin
      sat = SatMin;
    end else begin
      sat = SatMax;
    end
  end

  assign mem_we_o    = accept && (operation_i == plin_pkg::OpLoad) &&
                       (idx_ext < NW'(MAX_POINTS));
  assign mem_waddr_o = idx_ext[AW-1:0];
  assign mem_wdata_o = '{y: point_y_i, x: point_x_i};

  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    unique case (state_q)
      StIdle: begin
        mem_re_o = accept && (operation_i == plin_pkg::OpQuery);
      end
      StRdLast: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = last_idx;
      end
      StChkEnds: begin
        mem_re_o    = !q_lt_lo && !q_gt_rd;
        mem_raddr_o = last_idx - AW'(1);
      end
      StSearch: begin
        mem_re_o    = search_go;
        mem_raddr_o = idx_q - AW'(1);
      end
      default: begin
      end
    endcase
  end

  assign div_start_o    = (state_q == StDivGo);
  assign div_dividend_o = prod_q;
  assign div_divisor_o  = mw_q;

  assign res_valid_o = (state_q == StDone);
  assign res_y_o     = res_y_q;
  assign res_degen_o = res_degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      q_q         <= '0;
      lo_q        <= '0;
      up_q        <= '0;
      idx_q       <= '0;
      mdx_q       <= '0;
      mdy_q       <= '0;
      mw_q        <= '0;
      neg_q       <= 1'b0;
      wz_q        <= 1'b0;
      prod_q      <= '0;
      sq_q        <= '0;
      res_y_q     <= '0;
      res_degen_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (accept && (operation_i == plin_pkg::OpQuery)) begin
            q_q     <= query_x_i;
            state_q <= StRdLast;
          end
        end
        StRdLast: begin
          lo_q    <= mem_rdata_i;
          state_q <= StChkEnds;
        end
        StChkEnds: begin
          res_degen_q <= 1'b0;
          if (q_lt_lo) begin
            res_y_q <= lo_q.y;
            state_q <= StDone;
          end else if (q_gt_rd) begin
            res_y_q <= mem_rdata_i.y;
            state_q <= StDone;
          end else begin
            up_q    <= mem_rdata_i;
            idx_q   <= last_idx - AW'(1);
            state_q <= StSearch;
          end
        end
        StSearch: begin
          if (search_go) begin
            up_q  <= mem_rdata_i;
            idx_q <= idx_q - AW'(1);
          end else begin
            lo_q    <= mem_rdata_i;
            state_q <= StDiff;
          end
        end
        StDiff: begin
          mdx_q   <= mag(dx);
          mdy_q   <= mag(dy);
          mw_q    <= mag(w);
          neg_q   <= dx[DW] ^ dy[DW] ^ w[DW];
          wz_q    <= (up_q.x == lo_q.x);
          state_q <= StMul;
        end
        StMul: begin
          if (wz_q) begin
            res_y_q     <= lo_q.y;
            res_degen_q <= 1'b1;
            state_q     <= StDone;
          end else begin
            prod_q  <= mdx_q * mdy_q;
            state_q <= StDivGo;
          end
        end
        StDivGo: begin
          state_q <= StDivWait;
        end
        StDivWait: begin
          if (div_status_i.done && !div_status_i.busy) begin
            state_q <= StFix;
          end
        end
        StFix: begin
          sq_q    <= sq;
          state_q <= StSum;
        end
        StSum: begin
          res_y_q <= sat;
          state_q <= StDone;
        end
        StDone: begin
          if (res_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/piecewise_linear_interpolator_top.sv
// Piecewise linear interpolator over a breakpoint table in signed Q16.16.
// A load request writes one breakpoint into the table; the next request can be
// taken in the cycle after. A query clamped below the first or above the last
// breakpoint in use reads the first and last entries and ends at the end
// check. An interpolating query reads the table one entry a cycle, walking
// down from the last segment, then forms the differences and the product,
// runs the bit-serial divider, signs the clamped quotient and adds the lower y
// with saturation. A zero-width segment skips the divider. One query is in
// work at a time; the output register holds a finished result until it is
// taken, and a finished query waits in the sequencer while that register is
// full.
// ----------------------------------------------------------------------------
// Piecewise linear interpolator top level
// Configuration register, breakpoint table, divider, sequencer, output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_interpolator_top #(
  parameter int MAX_POINTS = plin_pkg::MaxPoints
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [plin_pkg::CountW-1:0]      cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [0:0]                       operation_i,
  input  wire  [plin_pkg::IndexW-1:0]      point_index_i,
  input  wire  [plin_pkg::DataW-1:0]       point_x_i,
  input  wire  [plin_pkg::DataW-1:0]       point_y_i,
  input  wire  [plin_pkg::DataW-1:0]       query_x_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [plin_pkg::DataW-1:0]       result_y_o,
  output logic [0:0]                       degenerate_segment_o
);

  localparam int AW = $clog2(MAX_POINTS);

  logic [plin_pkg::CountW-1:0] points_q;
  logic                        out_valid_q;
  logic [plin_pkg::DataW-1:0]  result_y_q;
  logic                        degen_q;

  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  plin_pkg::point_t            mem_wdata, mem_rdata;
  logic                        div_start;
  logic [plin_pkg::ProdW-1:0]  div_dividend, div_quotient;
  logic [plin_pkg::DataW-1:0]  div_divisor;
  plin_pkg::div_status_t       div_status;
  logic                        res_valid, res_ready, res_degen;
  logic [plin_pkg::DataW-1:0]  res_y;

  assign cfg_ready_o = 1'b1;
  assign res_ready   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q    <= plin_pkg::PointsReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        points_q <= cfg_data_i;
      end
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      result_y_q <= res_y;
      degen_q    <= res_degen;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign result_y_o           = result_y_q;
  assign degenerate_segment_o = degen_q;

  plin_mem #(
    .Depth (MAX_POINTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  plin_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .status_o   (div_status),
    .quotient_o (div_quotient)
  );

  plin_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .point_index_i   (point_index_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .query_x_i       (query_x_i),
    .points_in_use_i (points_q),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .div_start_o     (div_start),
    .div_dividend_o  (div_dividend),
    .div_divisor_o   (div_divisor),
    .div_status_i    (div_status),
    .div_quotient_i  (div_quotient),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_y_o         (res_y),
    .res_degen_o     (res_degen)
  );

endmodule

`default_nettype wire

>>> rtl/plin_checker.sv
// ----------------------------------------------------------------------------
// Interpolator port checker
// Watches the top level ports for result timing and request ordering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plin_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_ready_o,
  input wire [0:0]                    operation_i,
  input wire                          out_valid_o,
  input wire                          out_ready_i,
  input wire [plin_pkg::DataW-1:0]    result_y_o,
  input wire [0:0]                    degenerate_segment_o
);

  logic in_acc, query_acc;

  assign in_acc    = in_valid_i && in_ready_o;
  assign query_acc = in_acc && (operation_i == plin_pkg::OpQuery);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(result_y_o) && $stable(degenerate_segment_o))
    else $error("result changed while stalled");

  // a taken query lowers in_ready_o
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc |=> !in_ready_o)
    else $error("request taken during a query");

  // no result appears from an empty output stage right after a request
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc && !out_valid_o |=> !out_valid_o ##1 !out_valid_o)
    else $error("query result before the table reads");

endmodule

bind piecewise_linear_interpolator_top plin_checker u_checker (.*);

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Piecewise linear interpolator testbench
// Loads breakpoint tables, queries through them under random stalls on both
// sides across several table sizes, and checks every answer against a
// predictor of the clamp, search and interpolation arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic [31:0] y;
  logic        degen;
} answer_t;

class interp_scoreboard;
  logic signed [31:0]          x_tab [plin_pkg::MaxPoints];
  logic signed [31:0]          y_tab [plin_pkg::MaxPoints];
  logic [plin_pkg::CountW-1:0] points_reg;
  answer_t                     pending_answers [$];
  int unsigned                 mismatches;

  function new();
    points_reg = plin_pkg::PointsReset;
    mismatches = 0;
    foreach (x_tab[k]) begin
      x_tab[k] = '0;
      y_tab[k] = '0;
    end
  endfunction

  function void write_points(logic [plin_pkg::CountW-1:0] value);
    points_reg = value;
  endfunction

  function int active_points();
    int n;
    n = int'(points_reg);
    if (n < 2) n = 2;
    if (n > plin_pkg::MaxPoints) n = plin_pkg::MaxPoints;
    return n;
  endfunction

  function answer_t interpolate(logic signed [31:0] qx);
    int                n, i;
    longint            xi, yi, xn, yn, dx, dy, w, sq, res;
    longint unsigned   mdx, mdy, mw, prod, quo;
    logic              neg;
    answer_t           ans;
    n = active_points();
    ans.degen = 1'b0;
    if (qx < x_tab[0]) begin
      res = y_tab[0];
    end else if (qx > x_tab[n-1]) begin
      res = y_tab[n-1];
    end else begin
      i = n - 2;
      while (i > 0 && qx < x_tab[i]) i--;
      xi = x_tab[i];
      yi = y_tab[i];
      xn = x_tab[i+1];
      yn = y_tab[i+1];
      if (xn == xi) begin
        ans.degen = 1'b1;
        res = yi;
      end else begin
        dx = longint'(qx) - xi;
        dy = yn - yi;
        w  = xn - xi;
        neg = ((dx < 0) != (dy < 0)) != (w < 0);
        mdx = dx < 0 ? -dx : dx;
        mdy = dy < 0 ? -dy : dy;
        mw  = w < 0 ? -w : w;
        prod = mdx * mdy;
        quo = prod / mw;
        if (quo > (64'd1 << 33)) quo = 64'd1 << 33;
        sq = longint'(quo);
        if (neg && prod != 0) sq = -sq;
        res = yi + sq;
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
      end
    end
    ans.y = 32'(res);
    return ans;
  endfunction

  function void note_request(plin_pkg::op_e op, logic [plin_pkg::IndexW-1:0] idx,
                             logic [31:0] px, logic [31:0] py, logic [31:0] qx);
    if (op == plin_pkg::OpLoad) begin
      if (idx < plin_pkg::MaxPoints) begin
        x_tab[idx] = px;
        y_tab[idx] = py;
      end
    end else begin
      pending_answers.push_back(interpolate(qx));
    end
  endfunction

  function void check_answer(logic [31:0] y, logic degen);
    answer_t want;
    if (pending_answers.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: result_y %h degenerate %0d", y, degen);
      return;
    end
    want = pending_answers.pop_front();
    if (y !== want.y || degen !== want.degen) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: result_y exp %h got %h, degenerate exp %0d got %0d",
                 want.y, y, want.degen, degen);
    end
  endfunction
endclass

module tb;

  localparam int CycleLimit = 1000000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [plin_pkg::CountW-1:0]   cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  plin_pkg::op_e                 operation;
  logic [plin_pkg::IndexW-1:0]   point_index;
  logic [31:0]                   point_x;
  logic [31:0]                   point_y;
  logic [31:0]                   query_x;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [31:0]                   result_y;
  logic [0:0]                    degenerate;

  interp_scoreboard sb;
  bit               no_idle;
  int               cycles;

  piecewise_linear_interpolator_top i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .operation_i         (operation),
    .point_index_i       (point_index),
    .point_x_i           (point_x),
    .point_y_i           (point_y),
    .query_x_i           (query_x),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .result_y_o          (result_y),
    .degenerate_segment_o(degenerate)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("piecewise_linear_interpolator_top test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_answer(result_y, degenerate[0]);
    out_ready <= no_idle || ($urandom_range(99) >= 17);
  end

  task automatic push_request(plin_pkg::op_e op, logic [plin_pkg::IndexW-1:0] idx,
                              logic [31:0] px, logic [31:0] py, logic [31:0] qx);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    point_index <= idx;
    point_x     <= px;
    point_y     <= py;
    query_x     <= qx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, idx, px, py, qx);
  endtask

  task automatic load_point(logic [plin_pkg::IndexW-1:0] idx, logic [31:0] px,
                            logic [31:0] py);
    push_request(plin_pkg::OpLoad, idx, px, py, '0);
  endtask

  task automatic ask(logic [31:0] qx);
    push_request(plin_pkg::OpQuery, '0, '0, '0, qx);
  endtask

  // hold off until every answer is back, then let a trailing load settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_points(logic [plin_pkg::CountW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.write_points(value);
  endtask

  task automatic fill_table(int n);
    int          xs [$];
    int          mode, base, k;
    logic [31:0] yv;
    mode = $urandom_range(2);
    base = $signed($urandom) >>> 2;
    for (k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(99) < 10) xs.push_back(xs[k-1]);
      else if (mode == 0) xs.push_back($urandom);
      else xs.push_back(base + $urandom_range(1 << 26));
    end
    xs.sort();
    for (k = 0; k < n; k++) begin
      if (mode == 1) yv = int'($urandom_range(1 << 21)) - (1 << 20);
      else yv = $urandom;
      load_point(plin_pkg::IndexW'(k), xs[k], yv);
    end
  endtask

  function automatic logic [31:0] pick_query();
    int              n, k, kind;
    longint          lo, hi;
    longint unsigned r64;
    n = sb.active_points();
    k = $urandom_range(n - 2);
    lo = sb.x_tab[k];
    hi = sb.x_tab[k+1];
    r64 = {$urandom, $urandom};
    kind = $urandom_range(99);
    if (kind < 55) begin
      if (hi > lo) return 32'(lo + longint'(r64 % longint'(hi - lo + 1)));
      return 32'(lo);
    end
    if (kind < 70) return sb.x_tab[$urandom_range(n - 1)];
    if (kind < 80) return r64[0] ? sb.x_tab[0] - 1 : sb.x_tab[n-1] + 1;
    if (kind < 90) return $urandom;
    case (r64[2:1])
      2'd0:    return 32'h8000_0000;
      2'd1:    return 32'h7fff_ffff;
      2'd2:    return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  initial begin
    logic [plin_pkg::CountW-1:0] cfg_plan [14];
    int p, j;
    cfg_plan = '{7'd3, 7'd64, 7'd0, 7'd127, 7'd1, 7'd9, 7'd2, 7'd33, 7'd64, 7'd5,
                 7'd100, 7'd48, 7'd2, 7'd20};
    sb = new();
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    operation   <= plin_pkg::OpLoad;
    point_index <= '0;
    point_x     <= '0;
    point_y     <= '0;
    query_x     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // extreme two-point table
    load_point(6'd0, 32'h8000_0000, 32'h7fff_ffff);
    load_point(6'd1, 32'h7fff_ffff, 32'h8000_0000);
    ask(32'h8000_0000);
    ask(32'h7fff_ffff);
    ask(32'h0000_0000);
    ask(32'h0001_0000);
    load_point(6'd63, 32'hffff_ffff, 32'hffff_ffff);
    // zero-width segment and clamping on both sides
    load_point(6'd0, 32'h0005_0000, 32'h1234_5678);
    load_point(6'd1, 32'h0005_0000, 32'hffff_fff9);
    ask(32'h0005_0000);
    ask(32'h0004_ffff);
    ask(32'h0005_0001);
    load_point(6'd0, 32'hfffd_0000, 32'hc000_0000);
    load_point(6'd1, 32'h0007_0000, 32'h4000_0000);
    ask(32'h0000_0000);
    ask(32'hfffd_0000);
    ask(32'h0007_0000);
    ask(32'h0003_8000);

    for (p = 0; p < 14; p++) begin
      wait_idle();
      set_points(cfg_plan[p]);
      no_idle = (p == 1);
      fill_table(sb.active_points());
      for (j = 0; j < 60; j++) begin
        if ($urandom_range(99) < 8)
          load_point(plin_pkg::IndexW'($urandom_range(63)), $urandom, $urandom);
        else ask(pick_query());
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
      $display("piecewise_linear_interpolator_top test passed");
    end else begin
      $display("piecewise_linear_interpolator_top test failed");
    end
    $finish;
  end

endmodule
